// ----- src/subpixel_splat_accumulator_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the subpixel splat accumulator
// Clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SUBPIXEL_SPLAT_ACCUMULATOR_DEFINES_SVH
`define SUBPIXEL_SPLAT_ACCUMULATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ssa_pkg.sv -----
// ----------------------------------------------------------------------------
// ssa_pkg
// Types, constants and helper functions of the subpixel splat accumulator.
// ----------------------------------------------------------------------------
package ssa_pkg;

    localparam int DEF_MATRIX_WIDTH  = 16;
    localparam int DEF_MATRIX_HEIGHT = 16;

    localparam int POS_W   = 12;
    localparam int FRAC_W  = 8;
    localparam int INT_W   = POS_W - FRAC_W;
    localparam int COLOR_W = 8;
    localparam int PIXEL_W = 3 * COLOR_W;
    localparam int PROD_W  = 2 * COLOR_W;
    localparam int ADDR_W  = 8;
    // Wide enough for row * MATRIX_WIDTH + col at the largest matrix.
    localparam int CALC_W  = 17;

    localparam logic [COLOR_W-1:0] COLOR_MAX = 8'hFF;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PICK,
        ST_WGT,
        ST_MUL_R,
        ST_MUL_G,
        ST_MUL_B,
        ST_STORE
    } t_state;

    // Adds the upper byte of a colour product to a stored component, clamped at full scale.
    function automatic logic [COLOR_W-1:0] sat_add(input logic [COLOR_W-1:0] base,
                                                   input logic [PROD_W-1:0]  prod);
        logic [COLOR_W:0] sum;
        sum = {1'b0, base} + {1'b0, prod[PROD_W-1:COLOR_W]};
        return sum[COLOR_W] ? COLOR_MAX : sum[COLOR_W-1:0];
    endfunction

endpackage

// ----- src/ssa_ram.sv -----
// ----------------------------------------------------------------------------
// ssa_ram
// Generic single-port RAM with a registered read port.
// ----------------------------------------------------------------------------
module ssa_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/subpixel_splat_accumulator.sv -----
// ----------------------------------------------------------------------------
// subpixel_splat_accumulator
// Antialiased point plot: splats an RGB colour over a 2x2 pixel neighborhood.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_ready) takes a point in 4.8 fixed point and a
// colour. The four neighbors (col,row), (col+1,row), (col,row+1),
// (col+1,row+1) get bilinear shares of the colour, saturating-added into the
// framebuffer. Output channel (o_valid / i_ready) returns one transaction per
// updated pixel in that order, with o_last on the final one; neighbors outside
// the matrix are skipped and give no transaction.
// Each neighbor inside the matrix passes ST_PICK, ST_WGT, ST_MUL_R, ST_MUL_G,
// ST_MUL_B and ST_STORE in turn; a skipped neighbor ahead of the last inside
// one, or of a point with no neighbor inside, passes ST_PICK alone. The single
// 8x8 multiplier forms the weight and the three colour products of each pixel
// in turn, behind one framebuffer read.
// o_ready is high only between points; the next point is taken while the last
// result still waits in the output register.
// After reset the framebuffer is cleared to black, entry by entry; o_ready stays
// low until the clear is done.
// A stalled receiver holds the output register; work stops at the next pixel
// store until the pending transaction is taken.
// ----------------------------------------------------------------------------
module subpixel_splat_accumulator #(
    parameter int MATRIX_WIDTH  = ssa_pkg::DEF_MATRIX_WIDTH,
    parameter int MATRIX_HEIGHT = ssa_pkg::DEF_MATRIX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ssa_pkg::POS_W-1:0]     i_pos_x,
    input  logic [ssa_pkg::POS_W-1:0]     i_pos_y,
    input  logic [ssa_pkg::COLOR_W-1:0]   i_red,
    input  logic [ssa_pkg::COLOR_W-1:0]   i_green,
    input  logic [ssa_pkg::COLOR_W-1:0]   i_blue,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ssa_pkg::ADDR_W-1:0]    o_pixel_address,
    output logic [ssa_pkg::COLOR_W-1:0]   o_out_red,
    output logic [ssa_pkg::COLOR_W-1:0]   o_out_green,
    output logic [ssa_pkg::COLOR_W-1:0]   o_out_blue,
    output logic                          o_last
);

    import ssa_pkg::*;

    localparam int DEPTH = MATRIX_WIDTH * MATRIX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0]     LAST_ENTRY = AW'(DEPTH - 1);
    localparam logic [CALC_W-1:0] MW_C       = CALC_W'(MATRIX_WIDTH);
    localparam logic [CALC_W-1:0] MH_C       = CALC_W'(MATRIX_HEIGHT);

    t_state r_state, n_state;

    logic [1:0]          r_k, n_k;
    logic [3:0]          r_mask, n_mask;
    logic [FRAC_W-1:0]   r_fx, n_fx, r_fy, n_fy;
    logic [INT_W-1:0]    r_col0, n_col0, r_row0, n_row0;
    logic [COLOR_W-1:0]  r_red, n_red, r_green, n_green, r_blue, n_blue;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [COLOR_W-1:0]  r_w, n_w;
    logic [COLOR_W-1:0]  r_new_r, n_new_r, r_new_g, n_new_g;
    logic [CALC_W-1:0]   r_addr, n_addr;
    logic [AW-1:0]       r_clr, n_clr;

    logic                r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]   r_out_addr, n_out_addr;
    logic [COLOR_W-1:0]  r_out_red, n_out_red, r_out_green, n_out_green;
    logic [COLOR_W-1:0]  r_out_blue, n_out_blue;
    logic                r_out_last, n_out_last;

    logic                ram_en, ram_we;
    logic [AW-1:0]       ram_addr;
    logic [PIXEL_W-1:0]  ram_wdata, ram_rdata;

    logic [COLOR_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0]   mul_p;
    logic [FRAC_W-1:0]   wa, wb;
    logic [PROD_W-1:0]   wsum;
    logic [CALC_W-1:0]   nb_col, nb_row, nb_addr;
    logic [CALC_W-1:0]   in_col0, in_row0;
    logic [3:0]          in_mask;
    logic                in_c0, in_c1, in_r0, in_r1;
    logic                is_last;
    logic [COLOR_W-1:0]  new_b;

    ssa_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Shared 8x8 multiplier: weight product first, then the three colour products.
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Fractions pick the bilinear corner; 255 - f is the bitwise inverse.
    assign wa   = r_k[0] ? r_fx : ~r_fx;
    assign wb   = r_k[1] ? r_fy : ~r_fy;
    assign wsum = r_prod + PROD_W'(wa) + PROD_W'(wb);

    assign nb_col  = CALC_W'(r_col0) + CALC_W'(r_k[0]);
    assign nb_row  = CALC_W'(r_row0) + CALC_W'(r_k[1]);
    assign nb_addr = nb_row * MW_C + nb_col;

    assign in_col0 = CALC_W'(i_pos_x[POS_W-1:FRAC_W]);
    assign in_row0 = CALC_W'(i_pos_y[POS_W-1:FRAC_W]);
    assign in_c0   = in_col0 < MW_C;
    assign in_c1   = (in_col0 + CALC_W'(1)) < MW_C;
    assign in_r0   = in_row0 < MH_C;
    assign in_r1   = (in_row0 + CALC_W'(1)) < MH_C;
    assign in_mask = {in_c1 & in_r1, in_c0 & in_r1, in_c1 & in_r0, in_c0 & in_r0};

    // No neighbor above the current one is inside the matrix.
    assign is_last = ((r_mask >> r_k) >> 1) == 4'd0;
    assign new_b   = sat_add(ram_rdata[COLOR_W-1:0], r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
        r_k         <= n_k;
        r_mask      <= n_mask;
        r_fx        <= n_fx;
        r_fy        <= n_fy;
        r_col0      <= n_col0;
        r_row0      <= n_row0;
        r_red       <= n_red;
        r_green     <= n_green;
        r_blue      <= n_blue;
        r_prod      <= n_prod;
        r_w         <= n_w;
        r_new_r     <= n_new_r;
        r_new_g     <= n_new_g;
        r_addr      <= n_addr;
        r_out_addr  <= n_out_addr;
        r_out_red   <= n_out_red;
        r_out_green <= n_out_green;
        r_out_blue  <= n_out_blue;
        r_out_last  <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_k         = r_k;
        n_mask      = r_mask;
        n_fx        = r_fx;
        n_fy        = r_fy;
        n_col0      = r_col0;
        n_row0      = r_row0;
        n_red       = r_red;
        n_green     = r_green;
        n_blue      = r_blue;
        n_prod      = r_prod;
        n_w         = r_w;
        n_new_r     = r_new_r;
        n_new_g     = r_new_g;
        n_addr      = r_addr;
        n_out_addr  = r_out_addr;
        n_out_red   = r_out_red;
        n_out_green = r_out_green;
        n_out_blue  = r_out_blue;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid && !i_ready;
        o_ready     = 1'b0;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = r_addr[AW-1:0];
        ram_wdata   = {r_new_r, r_new_g, new_b};
        mul_a       = r_w;
        mul_b       = r_red;

        case (r_state)
            ST_CLEAR: begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + AW'(1);
                if (r_clr == LAST_ENTRY) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_fx    = i_pos_x[FRAC_W-1:0];
                    n_fy    = i_pos_y[FRAC_W-1:0];
                    n_col0  = i_pos_x[POS_W-1:FRAC_W];
                    n_row0  = i_pos_y[POS_W-1:FRAC_W];
                    n_red   = i_red;
                    n_green = i_green;
                    n_blue  = i_blue;
                    n_mask  = in_mask;
                    n_k     = 2'd0;
                    n_state = ST_PICK;
                end
            end
            ST_PICK: begin
                if (r_mask[r_k]) begin
                    mul_a    = wa;
                    mul_b    = wb;
                    n_prod   = mul_p;
                    ram_en   = 1'b1;
                    ram_addr = nb_addr[AW-1:0];
                    n_addr   = nb_addr;
                    n_state  = ST_WGT;
                end else if (r_k == 2'd3) begin
                    n_state = ST_IDLE;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            ST_WGT: begin
                n_w     = wsum[PROD_W-1:COLOR_W];
                n_state = ST_MUL_R;
            end
            ST_MUL_R: begin
                mul_b   = r_red;
                n_prod  = mul_p;
                n_state = ST_MUL_G;
            end
            ST_MUL_G: begin
                n_new_r = sat_add(ram_rdata[PIXEL_W-1:2*COLOR_W], r_prod);
                mul_b   = r_green;
                n_prod  = mul_p;
                n_state = ST_MUL_B;
            end
            ST_MUL_B: begin
                n_new_g = sat_add(ram_rdata[2*COLOR_W-1:COLOR_W], r_prod);
                mul_b   = r_blue;
                n_prod  = mul_p;
                n_state = ST_STORE;
            end
            ST_STORE: begin
                // Wait here while the previous transaction is still pending.
                if (!r_out_valid || i_ready) begin
                    ram_en      = 1'b1;
                    ram_we      = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_addr  = r_addr[ADDR_W-1:0];
                    n_out_red   = r_new_r;
                    n_out_green = r_new_g;
                    n_out_blue  = new_b;
                    n_out_last  = is_last;
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k     = r_k + 2'd1;
                        n_state = ST_PICK;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_valid         = r_out_valid;
    assign o_pixel_address = r_out_addr;
    assign o_out_red       = r_out_red;
    assign o_out_green     = r_out_green;
    assign o_out_blue      = r_out_blue;
    assign o_last          = r_out_last;

endmodule

// ----- src/ssa_checker.sv -----
// ----------------------------------------------------------------------------
// ssa_checker
// Port-level checks of the subpixel splat accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`include "subpixel_splat_accumulator_defines.svh"

module ssa_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_pixel_address,
    input logic [7:0] o_out_red,
    input logic [7:0] o_out_green,
    input logic [7:0] o_out_blue,
    input logic       o_last
);

    // A stalled result transaction keeps its payload.
    `SSA_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_pixel_address) && $stable(o_out_red) && $stable(o_out_green) && $stable(o_out_blue) && $stable(o_last), "output changed while stalled")

    // A point is worked on outside the idle state, so the block cannot take two in a row.
    `SSA_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready, "ready right after accept")

    // A pending pixel that is not the last one means the point is still in work.
    `SSA_ASSERT_NOW(a_busy_mid_point, o_valid && !o_last, !o_ready, "ready in the middle of a point")

endmodule

bind subpixel_splat_accumulator ssa_checker u_ssa_checker (.*);
